FILE: design/tksd_pkg.sv
// Package for the terminal key sequence decoder.
// Holds the transaction structs, the key codes and the byte constants.
// No dependencies.
package tksd_pkg;

    typedef enum logic [3:0] {
        KIND_PLAIN     = 4'd0,
        KIND_ESC       = 4'd1,
        KIND_UP        = 4'd2,
        KIND_DOWN      = 4'd3,
        KIND_RIGHT     = 4'd4,
        KIND_LEFT      = 4'd5,
        KIND_HOME      = 4'd6,
        KIND_END       = 4'd7,
        KIND_PAGE_UP   = 4'd8,
        KIND_PAGE_DOWN = 4'd9,
        KIND_INS       = 4'd10,
        KIND_DEL       = 4'd11,
        KIND_FAIL      = 4'd12
    } t_key_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       read_failed;
    } t_in_item;

    typedef struct packed {
        t_key_kind  key_kind;
        logic [7:0] key_byte;
    } t_out_item;

    localparam logic [7:0] CH_ESC     = 8'd27;
    localparam logic [7:0] CH_CSI     = 8'h9B;
    localparam logic [7:0] CH_BRACKET = 8'h5B;  // '['
    localparam logic [7:0] CH_SS3     = 8'h4F;  // 'O'
    localparam logic [7:0] CH_PGUP    = 8'h49;  // 'I'
    localparam logic [7:0] CH_PGDN    = 8'h47;  // 'G'
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_FINAL   = 8'h40;  // bytes below this are skipped

    // Keys named by a letter directly after the opener or as a final byte.
    function automatic t_key_kind letter_key(input logic [7:0] c);
        t_key_kind k;
        unique case (c)
            8'h41:   k = KIND_UP;     // 'A'
            8'h42:   k = KIND_DOWN;   // 'B'
            8'h43:   k = KIND_RIGHT;  // 'C'
            8'h44:   k = KIND_LEFT;   // 'D'
            8'h48:   k = KIND_HOME;   // 'H'
            8'h46:   k = KIND_END;    // 'F'
            default: k = KIND_ESC;
        endcase
        return k;
    endfunction

endpackage

FILE: design/terminal_key_sequence_decoder.sv
// Terminal key sequence decoder: one input register, the parse step, one result register.
// Depends on tksd_pkg for the transaction structs, key codes and byte constants.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one byte per transaction in
//   i_in_data (in_byte plus a read_failed flag). Output channel: o_out_valid /
//   i_out_stall carry one decoded key per transaction in o_out_data.
//   A transaction completes at a rising edge with valid high and stall low.
//   Every accepted byte yields zero or one key: bytes inside an escape
//   sequence yield nothing until the sequence completes or is broken off.
//   The byte that completes a key passes the input register and the parse
//   step; the key is then held in the result register and shown on o_out_valid.
//   Throughput: one byte per cycle while the receiver does not stall, set by
//   the combinational parse step between the two registers.
//   The parse step advances whenever the result register is empty or is being
//   taken, so a byte is accepted while a finished key still waits.
//   When the receiver stalls, the result register holds, the input register
//   fills, and o_in_stall rises until the receiver takes the key.
//   Reset (i_rst_n low, synchronous) empties both registers and returns the
//   parser to idle with a cleared parameter.
module terminal_key_sequence_decoder
    import tksd_pkg::*;
#(
    parameter int PARAM_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ESC    = 3'd1,
        PH_INTRO  = 3'd2,
        PH_DIGITS = 3'd3,
        PH_SKIP   = 3'd4
    } t_phase;

    localparam int AccWidth = PARAM_WIDTH + 4;

    t_phase                 r_phase, n_phase;
    logic                   r_bracket, n_bracket;
    logic [PARAM_WIDTH-1:0] r_param, n_param;
    logic                   r_in_vld;
    t_in_item               r_in;
    logic                   r_out_vld;
    t_out_item              r_out;

    logic                   emit;
    t_key_kind              emit_kind;
    logic [7:0]             emit_byte;
    logic                   out_free;
    logic                   advance;
    logic                   in_take;
    logic [7:0]             c;
    logic                   fail;
    logic                   is_digit;
    logic [3:0]             digit;
    logic [AccWidth-1:0]    acc;
    logic [PARAM_WIDTH-1:0] acc_sat;
    t_key_kind              fin_kind;
    logic                   tilde_final;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign advance    = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    assign c        = r_in.in_byte;
    assign fail     = r_in.read_failed;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign digit    = 4'(c - CH_ZERO);

    // Times ten plus digit, saturating at the parameter width.
    assign acc = (AccWidth'(r_param) << 3) + (AccWidth'(r_param) << 1) + AccWidth'(digit);
    assign acc_sat = (|acc[AccWidth-1:PARAM_WIDTH]) ? '1 : acc[PARAM_WIDTH-1:0];

    assign tilde_final = (c == CH_TILDE) || (c == CH_CARET) ||
                         (c == CH_DOLLAR) || (c == CH_AT);

    always_comb begin
        fin_kind = letter_key(c);
        if (fin_kind == KIND_ESC && tilde_final) begin
            if (r_param == PARAM_WIDTH'(1) || r_param == PARAM_WIDTH'(7)) begin
                fin_kind = KIND_HOME;
            end else if (r_param == PARAM_WIDTH'(2)) begin
                fin_kind = KIND_INS;
            end else if (r_param == PARAM_WIDTH'(3)) begin
                fin_kind = KIND_DEL;
            end else if (r_param == PARAM_WIDTH'(4) || r_param == PARAM_WIDTH'(8)) begin
                fin_kind = KIND_END;
            end else if (r_param == PARAM_WIDTH'(5)) begin
                fin_kind = KIND_PAGE_UP;
            end else if (r_param == PARAM_WIDTH'(6)) begin
                fin_kind = KIND_PAGE_DOWN;
            end
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_bracket = r_bracket;
        n_param   = r_param;
        emit      = 1'b0;
        emit_kind = KIND_ESC;
        emit_byte = 8'd0;
        unique case (r_phase)
            PH_ESC: begin
                if (fail || (c != CH_BRACKET && c != CH_SS3)) begin
                    emit    = 1'b1;
                    n_phase = PH_IDLE;
                end else begin
                    n_bracket = (c == CH_BRACKET);
                    n_phase   = PH_INTRO;
                end
            end
            PH_INTRO: begin
                n_phase = PH_IDLE;
                priority if (fail) begin
                    emit = 1'b1;
                end else if (r_bracket && c == CH_PGUP) begin
                    emit      = 1'b1;
                    emit_kind = KIND_PAGE_UP;
                end else if (r_bracket && c == CH_PGDN) begin
                    emit      = 1'b1;
                    emit_kind = KIND_PAGE_DOWN;
                end else if (is_digit) begin
                    n_param = PARAM_WIDTH'(digit);
                    n_phase = PH_DIGITS;
                end else begin
                    emit      = 1'b1;
                    emit_kind = letter_key(c);
                end
            end
            PH_DIGITS: begin
                priority if (fail) begin
                    emit    = 1'b1;
                    n_phase = PH_IDLE;
                end else if (is_digit) begin
                    n_param = acc_sat;
                end else if (c < CH_FINAL) begin
                    n_phase = PH_SKIP;
                end else begin
                    emit      = 1'b1;
                    emit_kind = fin_kind;
                    n_phase   = PH_IDLE;
                end
            end
            PH_SKIP: begin
                priority if (fail) begin
                    emit    = 1'b1;
                    n_phase = PH_IDLE;
                end else if (c >= CH_FINAL) begin
                    emit      = 1'b1;
                    emit_kind = fin_kind;
                    n_phase   = PH_IDLE;
                end else begin
                    n_phase = PH_SKIP;
                end
            end
            default: begin
                // Idle, and any phase code without a meaning.
                n_phase = PH_IDLE;
                priority if (fail) begin
                    emit      = 1'b1;
                    emit_kind = KIND_FAIL;
                end else if (c == CH_ESC) begin
                    n_phase = PH_ESC;
                end else if (c == CH_CSI) begin
                    n_bracket = 1'b1;
                    n_phase   = PH_INTRO;
                end else begin
                    emit      = 1'b1;
                    emit_kind = KIND_PLAIN;
                    emit_byte = c;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bracket <= 1'b0;
            r_param   <= '0;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
                r_in     <= i_in_data;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_phase   <= n_phase;
                r_bracket <= n_bracket;
                r_param   <= n_param;
            end
            if (out_free) begin
                r_out_vld <= advance && emit;
            end
            if (advance && emit) begin
                r_out.key_kind <= emit_kind;
                r_out.key_byte <= emit_byte;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

FILE: tb/sv/terminal_key_sequence_decoder_tb.sv
// Self-checking testbench for terminal_key_sequence_decoder: directed key sequences, then
// random well-formed, broken and noise byte streams with random idling on both channels.
// Depends on tksd_pkg and the decoder RTL; a scoreboard class predicts every decoded key.
`timescale 1ns / 1ps

module terminal_key_sequence_decoder_tb;
    import tksd_pkg::*;

    localparam int PARAM_WIDTH = 16;
    localparam int N_ITEMS     = 625;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_AFTER_ESC,
        SEQ_OPENED,
        SEQ_DIGITS,
        SEQ_SKIP
    } t_seq_phase;

    // Tracks the parser state of the decoder and holds the keys still owed by it.
    class key_scoreboard;
        t_seq_phase        phase;
        bit                bracket_intro;
        longint unsigned   param;
        t_out_item         expected_keys[$];
        int unsigned       n_errors;
        int unsigned       n_checked;
        bit                kind_hit[16];

        function new();
            phase         = SEQ_IDLE;
            bracket_intro = 1'b0;
            param         = 0;
            n_errors      = 0;
            n_checked     = 0;
        endfunction

        function t_key_kind decode_letter(logic [7:0] c);
            case (c)
                8'h41:   return KIND_UP;     // 'A'
                8'h42:   return KIND_DOWN;   // 'B'
                8'h43:   return KIND_RIGHT;  // 'C'
                8'h44:   return KIND_LEFT;   // 'D'
                8'h48:   return KIND_HOME;   // 'H'
                8'h46:   return KIND_END;    // 'F'
                default: return KIND_ESC;
            endcase
        endfunction

        // A final byte is either a letter or a tilde-style final that needs the parameter.
        function t_key_kind decode_final(logic [7:0] c);
            t_key_kind k;
            k = decode_letter(c);
            if (k != KIND_ESC)
                return k;
            if (c == CH_TILDE || c == CH_CARET || c == CH_DOLLAR || c == CH_AT) begin
                case (param)
                    1, 7:    return KIND_HOME;
                    2:       return KIND_INS;
                    3:       return KIND_DEL;
                    4, 8:    return KIND_END;
                    5:       return KIND_PAGE_UP;
                    6:       return KIND_PAGE_DOWN;
                    default: return KIND_ESC;
                endcase
            end
            return KIND_ESC;
        endfunction

        function void add_digit(logic [7:0] c);
            longint unsigned ceiling;
            longint unsigned acc;
            ceiling = (64'd1 << PARAM_WIDTH) - 1;
            acc     = param * 10 + 64'(c - CH_ZERO);
            param   = (acc > ceiling) ? ceiling : acc;
        endfunction

        // Advances the parser by one byte; returns 1 when the byte completes a key.
        function bit advance_parser(t_in_item it, output t_out_item key);
            logic [7:0] c;
            bit         fail;
            bit         digit;
            c     = it.in_byte;
            fail  = it.read_failed;
            digit = (c >= CH_ZERO && c <= CH_NINE);
            key.key_kind = KIND_ESC;
            key.key_byte = 8'h00;
            case (phase)
                SEQ_AFTER_ESC: begin
                    if (fail || (c != CH_BRACKET && c != CH_SS3)) begin
                        phase = SEQ_IDLE;
                        return 1'b1;
                    end
                    bracket_intro = (c == CH_BRACKET);
                    phase = SEQ_OPENED;
                    return 1'b0;
                end
                SEQ_OPENED: begin
                    if (!fail && digit) begin
                        param = 64'(c - CH_ZERO);
                        phase = SEQ_DIGITS;
                        return 1'b0;
                    end
                    phase = SEQ_IDLE;
                    if (fail)
                        key.key_kind = KIND_ESC;
                    else if (bracket_intro && c == CH_PGUP)
                        key.key_kind = KIND_PAGE_UP;
                    else if (bracket_intro && c == CH_PGDN)
                        key.key_kind = KIND_PAGE_DOWN;
                    else
                        key.key_kind = decode_letter(c);
                    return 1'b1;
                end
                SEQ_DIGITS, SEQ_SKIP: begin
                    if (fail) begin
                        phase = SEQ_IDLE;
                        return 1'b1;
                    end
                    if (phase == SEQ_DIGITS && digit) begin
                        add_digit(c);
                        return 1'b0;
                    end
                    if (c < CH_FINAL) begin
                        phase = SEQ_SKIP;
                        return 1'b0;
                    end
                    key.key_kind = decode_final(c);
                    phase = SEQ_IDLE;
                    return 1'b1;
                end
                default: begin
                    phase = SEQ_IDLE;
                    if (fail) begin
                        key.key_kind = KIND_FAIL;
                        return 1'b1;
                    end
                    if (c == CH_ESC) begin
                        phase = SEQ_AFTER_ESC;
                        return 1'b0;
                    end
                    if (c == CH_CSI) begin
                        bracket_intro = 1'b1;
                        phase = SEQ_OPENED;
                        return 1'b0;
                    end
                    key.key_kind = KIND_PLAIN;
                    key.key_byte = c;
                    return 1'b1;
                end
            endcase
        endfunction

        function void note_input(t_in_item it);
            t_out_item key;
            if (advance_parser(it, key)) begin
                expected_keys.push_back(key);
                kind_hit[key.key_kind] = 1'b1;
            end
        endfunction

        function void check_key(t_out_item got);
            t_out_item want;
            if (expected_keys.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected key, expected none, actual kind %0d byte 0x%02h",
                         $time, got.key_kind, got.key_byte);
                return;
            end
            want = expected_keys.pop_front();
            n_checked++;
            if (got.key_kind !== want.key_kind) begin
                n_errors++;
                $display("%0t: key_kind mismatch, expected %0d, actual %0d",
                         $time, want.key_kind, got.key_kind);
            end
            if (got.key_byte !== want.key_byte) begin
                n_errors++;
                $display("%0t: key_byte mismatch, expected 0x%02h, actual 0x%02h",
                         $time, want.key_byte, got.key_byte);
            end
        endfunction

        function int pending_count();
            return expected_keys.size();
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    key_scoreboard board;
    int unsigned   n_fed         = 0;
    bit            tx_quiet      = 1'b0;
    bit            rx_quiet      = 1'b0;
    bit            hold_request  = 1'b0;
    int            rx_hold_left  = 0;
    int            rx_stall_left = 0;

    terminal_key_sequence_decoder #(
        .PARAM_WIDTH(PARAM_WIDTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 9))
            0:       return 8'h41;
            1:       return 8'h42;
            2:       return 8'h43;
            3:       return 8'h44;
            4:       return 8'h48;
            5:       return 8'h46;
            6:       return CH_PGUP;
            7:       return CH_PGDN;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_final();
        case ($urandom_range(0, 7))
            0:       return CH_TILDE;
            1:       return CH_CARET;
            2:       return CH_DOLLAR;
            3:       return CH_AT;
            4, 5:    return pick_letter();
            default: return 8'($urandom_range(8'h40, 8'hFF));
        endcase
    endfunction

    task automatic tx_idle(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Offers one byte and holds it until the decoder takes the transaction.
    task automatic feed(input logic [7:0] b, input bit fail = 1'b0);
        t_in_item it;
        it.in_byte     = b;
        it.read_failed = fail;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        board.note_input(it);
        n_fed++;
        if (!tx_quiet && $urandom_range(0, 3) == 0)
            tx_idle(pick_gap());
    endtask

    task automatic random_sequence();
        int opener;
        int n_digits;
        int n_skip;
        opener = $urandom_range(0, 2);
        if (opener == 0) begin
            feed(CH_CSI);
        end else begin
            feed(CH_ESC);
            feed(opener == 1 ? CH_BRACKET : CH_SS3);
        end
        if ($urandom_range(0, 9) < 4) begin
            feed(pick_letter());
        end else begin
            // Long digit runs are rare; they can push the parameter into saturation.
            n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 2);
            repeat (n_digits) feed(8'($urandom_range(CH_ZERO, CH_NINE)));
            n_skip = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
            repeat (n_skip) feed(8'($urandom_range(8'h00, 8'h3F)));
            feed(pick_final());
        end
    endtask

    task automatic broken_sequence();
        if ($urandom_range(0, 1) == 0)
            feed(CH_ESC);
        else
            feed(CH_CSI);
        repeat ($urandom_range(1, 4))
            feed(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    endtask

    // Holds the input idle until every owed key has come.
    task automatic wait_for_keys();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending_count() != 0);
    endtask

    // Receiver: checks every taken key, then decides the stall for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_key(o_out_data);
        if (hold_request) begin
            hold_request = 1'b0;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_stall <= 1'b1;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if (!rx_quiet && $urandom_range(0, 3) == 0)
                rx_stall_left = pick_gap();
        end
    end

    initial begin
        int  n_kinds;
        bit  hold_done;
        bit  pause_done;
        board      = new();
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: extremes, each opener, and the special endings.
        feed(8'h00);
        feed(8'hFF);
        feed(8'hFF, 1'b1);                      // failed read while idle
        feed(CH_ESC); feed(CH_BRACKET); feed(8'h41);
        feed(CH_CSI); feed(CH_PGDN);
        feed(CH_ESC); feed(8'h71);              // byte after ESC is not an opener
        feed(CH_ESC); feed(CH_SS3); feed(8'h7A); // unrecognized ending
        feed(CH_ESC); feed(8'h00, 1'b1);        // failed read inside a sequence
        feed(CH_ESC); feed(CH_BRACKET);
        repeat (6) feed(CH_NINE);               // parameter saturates
        feed(CH_TILDE);

        while (n_fed < N_ITEMS) begin
            if (!hold_done && n_fed >= 200) begin
                // Keep offering bytes back to back while the receiver holds off.
                hold_done    = 1'b1;
                hold_request = 1'b1;
                tx_quiet     = 1'b1;
            end
            if (hold_done && tx_quiet && n_fed >= 320)
                tx_quiet = 1'b0;
            if (!pause_done && n_fed >= 420) begin
                pause_done = 1'b1;
                wait_for_keys();
            end
            rx_quiet = (n_fed >= 100 && n_fed < 150) || (n_fed >= 480 && n_fed < 520);
            if (n_fed >= 480 && n_fed < 520)
                tx_quiet = 1'b1;
            else if (n_fed >= 520)
                tx_quiet = 1'b0;
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6:
                    feed(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                17, 18, 19:
                    broken_sequence();
                default:
                    random_sequence();
            endcase
        end

        wait_for_keys();
        repeat (10) @(posedge i_clk);

        n_kinds = 0;
        for (int k = 0; k < 16; k++)
            if (board.kind_hit[k])
                n_kinds++;
        $display("Summary: %0d bytes fed, %0d keys checked, %0d of 13 key kinds produced",
                 n_fed, board.n_checked, n_kinds);
        if (board.n_errors == 0 && board.pending_count() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout: %0d keys still outstanding", board.pending_count());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
